// ===== rtl/link_keepalive_ping_monitor_defines.svh =====
// ---------------------------------------------------------------------------
// Keepalive monitor assertion macros
// Shared property wrappers, clocked on aclk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef LINK_KEEPALIVE_PING_MONITOR_DEFINES_SVH
`define LINK_KEEPALIVE_PING_MONITOR_DEFINES_SVH

// same-cycle implication
`define LKPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LKPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lkpm_pkg.sv =====
// ---------------------------------------------------------------------------
// Keepalive monitor package
// Codes, register defaults, request and result types shared by the RTL.
// ---------------------------------------------------------------------------
package lkpm_pkg;

    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INTERVAL      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FAILURE_LIMIT = 8'd1;

    localparam logic [15:0] INTERVAL_RST      = 16'd1000;
    localparam logic [7:0]  FAILURE_LIMIT_RST = 8'd3;

    localparam logic [7:0] TYPE_NOACK = 8'd2;
    localparam logic [7:0] FAIL_MAX   = 8'd255;
    localparam logic [3:0] FULL_LEN   = 4'd8;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RX_PING = 2'd1,
        OP_RX_PONG = 2'd2,
        OP_RX_DATA = 2'd3
    } lkpm_op_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_PING = 2'd1,
        KIND_PONG = 2'd2
    } lkpm_kind_t;

    typedef enum logic [2:0] {
        PS_NONE     = 3'd0,
        PS_OK       = 3'd1,
        PS_IDLE     = 3'd2,
        PS_BADLEN   = 3'd3,
        PS_MISMATCH = 3'd4
    } lkpm_pstat_t;

    typedef struct packed {
        lkpm_op_t    op;
        logic [63:0] now_us;
        logic [15:0] rx_seq;
        logic [7:0]  rx_type;
        logic [63:0] payload_value;
        logic [3:0]  payload_len;
    } lkpm_req_t;

    typedef struct packed {
        lkpm_kind_t  tx_kind;
        logic [15:0] tx_seq;
        logic [7:0]  tx_type;
        logic [63:0] tx_payload;
        logic [3:0]  tx_len;
        logic        link_up;
        logic        link_changed;
        logic [31:0] delay_us;
        lkpm_pstat_t pong_status;
        logic [7:0]  failure_count;
    } lkpm_result_t;

    // handshake between request stage and core
    typedef struct packed {
        logic valid;
        logic take;
    } lkpm_hs_t;

    // byte mask for an echo of len bytes (len already clamped to 8)
    function automatic logic [63:0] byte_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/link_keepalive_ping_monitor.sv =====
// ---------------------------------------------------------------------------
// Link keepalive ping monitor
// Keepalive ping/pong supervisor for one link. Tick requests run a period
// counter; on expiry a ping carrying the current time and the next sequence
// number goes out, and an unanswered earlier ping counts as a failure
// (saturating at 255) until the failure limit takes the link down. A
// received ping is echoed as a pong (payload clamped to 8 bytes); a received
// pong with an 8-byte payload equal to the stored ping time yields the
// round-trip delay and brings the link up. Every received frame restarts the
// period and clears the failures. Each request gives exactly one result.
// Timing: one request per cycle while the result register is free or m_ready
// drains it; m_valid rises when the core takes the request from the request register.
// Path: request register -> one compare/update step (17-bit period
// compare, 64-bit payload compare, 32-bit delay subtract) -> result register.
// The request register refills in the same cycle the core takes it, so while
// a finished result waits on m_ready one further request is still taken into
// an empty request register.
// Registers (cfg_wr_en / cfg_index / cfg_wdata, write-only, no wait):
//   index 0 interval       16 bits, reset 1000, 0 disables pings
//   index 1 failure_limit  8 bits, reset 3
// Other indexes are ignored. Write only while the monitor is idle.
// ---------------------------------------------------------------------------
module link_keepalive_ping_monitor (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [lkpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lkpm_pkg::CFG_DATA_W-1:0] cfg_wdata,

    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_op,
    input  logic [63:0]                     s_now_us,
    input  logic [15:0]                     s_rx_seq,
    input  logic [7:0]                      s_rx_type,
    input  logic [63:0]                     s_payload_value,
    input  logic [3:0]                      s_payload_len,

    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_tx_kind,
    output logic [15:0]                     m_tx_seq,
    output logic [7:0]                      m_tx_type,
    output logic [63:0]                     m_tx_payload,
    output logic [3:0]                      m_tx_len,
    output logic                            m_link_up,
    output logic                            m_link_changed,
    output logic [31:0]                     m_delay_us,
    output logic [2:0]                      m_pong_status,
    output logic [7:0]                      m_failure_count
);

    lkpm_pkg::lkpm_req_t    s_req;
    lkpm_pkg::lkpm_req_t    req;
    lkpm_pkg::lkpm_hs_t     hs;
    lkpm_pkg::lkpm_result_t res;
    logic                   take;

    // pack the request fields
    assign s_req.op            = lkpm_pkg::lkpm_op_t'(s_op);
    assign s_req.now_us        = s_now_us;
    assign s_req.rx_seq        = s_rx_seq;
    assign s_req.rx_type       = s_rx_type;
    assign s_req.payload_value = s_payload_value;
    assign s_req.payload_len   = s_payload_len;

    lkpm_req_stage u_req_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .take    (take),
        .hs      (hs),
        .req     (req)
    );

    lkpm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (hs.valid),
        .req       (req),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    // unpack the result register
    assign m_tx_kind       = res.tx_kind;
    assign m_tx_seq        = res.tx_seq;
    assign m_tx_type       = res.tx_type;
    assign m_tx_payload    = res.tx_payload;
    assign m_tx_len        = res.tx_len;
    assign m_link_up       = res.link_up;
    assign m_link_changed  = res.link_changed;
    assign m_delay_us      = res.delay_us;
    assign m_pong_status   = res.pong_status;
    assign m_failure_count = res.failure_count;

endmodule

// ===== rtl/lkpm_req_stage.sv =====
// ---------------------------------------------------------------------------
// Keepalive monitor request stage
// Registers one incoming request; refills in the cycle the core takes it.
// ---------------------------------------------------------------------------
module lkpm_req_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lkpm_pkg::lkpm_req_t s_req,
    input  logic               take,
    output lkpm_pkg::lkpm_hs_t hs,
    output lkpm_pkg::lkpm_req_t req
);

    logic                valid_reg;
    logic                valid_next;
    lkpm_pkg::lkpm_req_t req_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

    assign hs.valid = valid_reg;
    assign hs.take  = take;
    assign req      = req_reg;

endmodule

// ===== rtl/lkpm_core.sv =====
// ---------------------------------------------------------------------------
// Keepalive monitor core
// Link state, ping timer and pong check; one request per cycle into the
// result register while it is free or m_ready drains it.
// ---------------------------------------------------------------------------
`include "link_keepalive_ping_monitor_defines.svh"

module lkpm_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lkpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lkpm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                in_valid,
    input  lkpm_pkg::lkpm_req_t                 req,
    output logic                                take,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lkpm_pkg::lkpm_result_t              res
);

    // configuration
    logic [15:0] interval_reg;
    logic [7:0]  failure_limit_reg;

    // monitor state
    logic [15:0] period_count_reg, period_count_next;
    logic [15:0] next_seq_reg, next_seq_next;
    logic        outstanding_reg, outstanding_next;
    logic [63:0] start_time_reg, start_time_next;
    logic [7:0]  failures_reg, failures_next;
    logic        link_reg, link_next;
    logic [31:0] last_delay_reg, last_delay_next;

    logic                   m_valid_reg;
    lkpm_pkg::lkpm_result_t res_reg, res_next;

    logic [16:0] cnt;
    logic [7:0]  fail_inc;
    logic [3:0]  echo_len;
    logic        ping_fire;

    assign take = in_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg      <= lkpm_pkg::INTERVAL_RST;
            failure_limit_reg <= lkpm_pkg::FAILURE_LIMIT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == lkpm_pkg::CFG_IDX_INTERVAL) begin
                interval_reg <= cfg_wdata;
            end else if (cfg_index == lkpm_pkg::CFG_IDX_FAILURE_LIMIT) begin
                failure_limit_reg <= cfg_wdata[7:0];
            end
        end
    end

    assign cnt       = {1'b0, period_count_reg} + 17'd1;
    assign fail_inc  = (failures_reg != lkpm_pkg::FAIL_MAX) ? failures_reg + 8'd1
                                                            : failures_reg;
    assign echo_len  = (req.payload_len > lkpm_pkg::FULL_LEN) ? lkpm_pkg::FULL_LEN
                                                              : req.payload_len;
    assign ping_fire = (req.op == lkpm_pkg::OP_TICK) && (interval_reg != 16'd0)
                       && (cnt >= {1'b0, interval_reg});

    always_comb begin
        period_count_next = period_count_reg;
        next_seq_next     = next_seq_reg;
        outstanding_next  = outstanding_reg;
        start_time_next   = start_time_reg;
        failures_next     = failures_reg;
        link_next         = link_reg;
        last_delay_next   = last_delay_reg;

        res_next             = '0;
        res_next.tx_kind     = lkpm_pkg::KIND_NONE;
        res_next.pong_status = lkpm_pkg::PS_NONE;

        case (req.op)
            lkpm_pkg::OP_TICK: begin
                if (interval_reg == 16'd0) begin
                    period_count_next = '0;
                end else if (ping_fire) begin
                    period_count_next = '0;
                    if (outstanding_reg) begin
                        failures_next = fail_inc;
                        if (fail_inc >= failure_limit_reg) begin
                            link_next = 1'b0;
                        end
                    end
                    start_time_next     = req.now_us;
                    res_next.tx_kind    = lkpm_pkg::KIND_PING;
                    res_next.tx_seq     = next_seq_reg;
                    res_next.tx_type    = lkpm_pkg::TYPE_NOACK;
                    res_next.tx_payload = req.now_us;
                    res_next.tx_len     = lkpm_pkg::FULL_LEN;
                    next_seq_next       = next_seq_reg + 16'd1;
                    outstanding_next    = 1'b1;
                end else begin
                    period_count_next = cnt[15:0];
                end
            end
            lkpm_pkg::OP_RX_PING: begin
                res_next.tx_kind    = lkpm_pkg::KIND_PONG;
                res_next.tx_seq     = req.rx_seq;
                res_next.tx_type    = req.rx_type;
                res_next.tx_payload = req.payload_value & lkpm_pkg::byte_mask(echo_len);
                res_next.tx_len     = echo_len;
                period_count_next   = '0;
                failures_next       = '0;
            end
            lkpm_pkg::OP_RX_PONG: begin
                if (!outstanding_reg) begin
                    res_next.pong_status = lkpm_pkg::PS_IDLE;
                end else if (req.payload_len != lkpm_pkg::FULL_LEN) begin
                    res_next.pong_status = lkpm_pkg::PS_BADLEN;
                end else if (req.payload_value != start_time_reg) begin
                    res_next.pong_status = lkpm_pkg::PS_MISMATCH;
                end else begin
                    res_next.pong_status = lkpm_pkg::PS_OK;
                    outstanding_next     = 1'b0;
                    last_delay_next      = req.now_us[31:0] - start_time_reg[31:0];
                    link_next            = 1'b1;
                end
                period_count_next = '0;
                failures_next     = '0;
            end
            default: begin
                period_count_next = '0;
                failures_next     = '0;
            end
        endcase

        res_next.link_up       = link_next;
        res_next.link_changed  = link_next != link_reg;
        res_next.delay_us      = last_delay_next;
        res_next.failure_count = failures_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_count_reg <= '0;
            next_seq_reg     <= '0;
            outstanding_reg  <= 1'b0;
            start_time_reg   <= '0;
            failures_reg     <= '0;
            link_reg         <= 1'b1;
            last_delay_reg   <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (take) begin
                period_count_reg <= period_count_next;
                next_seq_reg     <= next_seq_next;
                outstanding_reg  <= outstanding_next;
                start_time_reg   <= start_time_next;
                failures_reg     <= failures_next;
                link_reg         <= link_next;
                last_delay_reg   <= last_delay_next;
            end
            m_valid_reg <= take || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign res     = res_reg;

    `LKPM_ASSERT_NEXT(a_seq_step, take && ping_fire, next_seq_reg == $past(next_seq_reg) + 16'd1 && outstanding_reg, "ping sent without sequence step or outstanding flag")
    `LKPM_ASSERT_NEXT(a_rx_clears_fail, take && req.op != lkpm_pkg::OP_TICK, failures_reg == 8'd0 && period_count_reg == 16'd0, "received item did not clear failures and period")
    `LKPM_ASSERT_NOW(a_pong_ok_up, m_valid_reg && res_reg.pong_status == lkpm_pkg::PS_OK, res_reg.link_up && !outstanding_reg, "accepted pong without link up")
    `LKPM_ASSERT_NOW(a_link_matches, m_valid_reg, res_reg.link_up == link_reg || in_valid, "reported link status disagrees with state")

endmodule
